### design/bsf_pkg.sv
// bsf_pkg: shared types, constants and the helper function of the balance
// state-feedback controller. Used by bsf_mul and balance_state_feedback.
// No dependencies.
`timescale 1ns / 1ps

package bsf_pkg;

   // Number format and serial multiplier geometry
   localparam int FRAC_BITS    = 16;
   localparam int WORD_WIDTH   = 32;
   localparam int DIGIT_WIDTH  = 4;
   localparam int DIGIT_COUNT  = WORD_WIDTH / DIGIT_WIDTH;
   localparam int COUNT_WIDTH  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   // Field widths of the channels
   localparam int ANGLE_WIDTH    = 32;
   localparam int RATE_WIDTH     = 32;
   localparam int STEP_WIDTH     = 16;
   localparam int SPEED_WIDTH    = 32;
   localparam int DRIVE_WIDTH    = 32;
   localparam int GAIN_WIDTH     = 32;
   localparam int RADIUS_WIDTH   = 16;
   localparam int REQ_DATA_WIDTH = ANGLE_WIDTH + RATE_WIDTH + STEP_WIDTH + SPEED_WIDTH;
   localparam int RSP_DATA_WIDTH = DRIVE_WIDTH;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_INDEX_WIDTH = 3;

   // Bit offsets inside req_tdata
   localparam int ANGLE_LSB = 0;
   localparam int RATE_LSB  = ANGLE_LSB + ANGLE_WIDTH;
   localparam int STEP_LSB  = RATE_LSB + RATE_WIDTH;
   localparam int SPEED_LSB = STEP_LSB + STEP_WIDTH;

   // Five gain products summed exactly before the final saturation
   localparam int SUM_WIDTH = WORD_WIDTH + 3;

   // Register indexes of the configuration port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_POSITION   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_VELOCITY   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_ANGLE      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_ANGLE_RATE = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GAIN_INTEGRAL   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WHEEL_RADIUS    = 3'd5;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 16'd3277;

   // Fixed-point constants, rounded to nearest
   localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
   localparam longint ALPHA_Q   = (3 * ONE_Q + 5) / 10;
   localparam longint NEAR_Q    = (5 * ONE_Q + 500) / 1000;
   localparam longint LEAK_Q    = (98 * ONE_Q + 50) / 100;
   localparam longint SPEED_Q   = 100 * ONE_Q;
   localparam longint INTEG_Q   = 20 * ONE_Q;
   localparam longint DRIVE_MAX = (longint'(1) << (DRIVE_WIDTH - 1)) - 1;

   localparam logic signed [WORD_WIDTH-1:0] ALPHA_WORD     = WORD_WIDTH'(ALPHA_Q);
   localparam logic signed [WORD_WIDTH-1:0] ONE_LESS_ALPHA = WORD_WIDTH'(ONE_Q - ALPHA_Q);
   localparam logic signed [WORD_WIDTH-1:0] LEAK_WORD      = WORD_WIDTH'(LEAK_Q);
   localparam logic signed [WORD_WIDTH-1:0] NEAR_HI        = WORD_WIDTH'(NEAR_Q);
   localparam logic signed [WORD_WIDTH-1:0] NEAR_LO        = WORD_WIDTH'(-NEAR_Q);
   localparam logic signed [WORD_WIDTH-1:0] INTEG_HI       = WORD_WIDTH'(INTEG_Q);
   localparam logic signed [WORD_WIDTH-1:0] INTEG_LO       = WORD_WIDTH'(-INTEG_Q);
   localparam logic signed [SPEED_WIDTH-1:0] SPEED_HI      = SPEED_WIDTH'(SPEED_Q);
   localparam logic signed [SPEED_WIDTH-1:0] SPEED_LO      = SPEED_WIDTH'(-SPEED_Q);
   localparam logic signed [SUM_WIDTH:0] DRIVE_HI          = (SUM_WIDTH + 1)'(DRIVE_MAX);
   localparam logic signed [SUM_WIDTH:0] DRIVE_LO          = (SUM_WIDTH + 1)'(-DRIVE_MAX - 1);

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_VEL,
      S_POS,
      S_FILT_A,
      S_FILT_B,
      S_INTEG,
      S_LEAK,
      S_CLAMP,
      S_GAIN_POS,
      S_GAIN_VEL,
      S_GAIN_ANGLE,
      S_GAIN_RATE,
      S_GAIN_INTEG,
      S_OUT
   } bsf_state_type;

   // Multiplier request and response
   typedef struct packed {
      logic                          start;
      logic signed [WORD_WIDTH-1:0]  op_a;
      logic signed [WORD_WIDTH-1:0]  op_b;
   } bsf_mul_req_type;

   typedef struct packed {
      logic                          done;
      logic signed [WORD_WIDTH-1:0]  product;
   } bsf_mul_rsp_type;

   // Add two words, saturate to the word range
   function automatic logic signed [WORD_WIDTH-1:0] sat_add(
      input logic signed [WORD_WIDTH-1:0] a,
      input logic signed [WORD_WIDTH-1:0] b
   );
      logic signed [WORD_WIDTH:0] s;
      logic signed [WORD_WIDTH-1:0] r;
      s = (WORD_WIDTH + 1)'(a) + (WORD_WIDTH + 1)'(b);
      if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
         r = s[WORD_WIDTH] ? {1'b1, {(WORD_WIDTH - 1){1'b0}}}
                           : {1'b0, {(WORD_WIDTH - 1){1'b1}}};
      end else begin
         r = s[WORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

### design/bsf_mul.sv
// bsf_mul: digit-serial signed fixed-point multiplier, sign-magnitude with
// round-half-away-from-zero at FRAC_BITS and saturation to the word.
// Depends on bsf_pkg.
`timescale 1ns / 1ps

module bsf_mul (
   input  logic                     clock,
   input  logic                     reset,
   input  bsf_pkg::bsf_mul_req_type mul_req,
   output bsf_pkg::bsf_mul_rsp_type mul_rsp
);
   import bsf_pkg::*;

   localparam int ACC_WIDTH  = WORD_WIDTH + DIGIT_WIDTH;
   localparam int FULL_WIDTH = 2 * WORD_WIDTH;
   localparam int Q_WIDTH    = FULL_WIDTH - FRAC_BITS;

   logic [WORD_WIDTH-1:0]  mcand_ff, mcand_in;
   logic [WORD_WIDTH-1:0]  mplier_ff, mplier_in;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [WORD_WIDTH-1:0]  low_ff, low_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   neg_ff, neg_in;
   logic                   busy_ff, busy_in;
   logic                   fin_ff, fin_in;
   logic                   done_ff, done_in;
   logic signed [WORD_WIDTH-1:0] prod_ff, prod_in;

   logic [ACC_WIDTH-1:0]  partial;
   logic [ACC_WIDTH-1:0]  digit_sum;
   logic [FULL_WIDTH-1:0] full;
   logic [Q_WIDTH-1:0]    quot;
   logic                  over_pos;
   logic                  over_neg;

   // Digit step: add magnitude times one multiplier digit, shift one digit right
   always_comb begin
      partial   = {{DIGIT_WIDTH{1'b0}}, mcand_ff} *
                  {{WORD_WIDTH{1'b0}}, mplier_ff[DIGIT_WIDTH-1:0]};
      digit_sum = acc_ff + partial;
      full      = {acc_ff[WORD_WIDTH-1:0], low_ff};
      quot      = full[FULL_WIDTH-1:FRAC_BITS];
      over_pos  = |quot[Q_WIDTH-1:WORD_WIDTH-1];
      over_neg  = (|quot[Q_WIDTH-1:WORD_WIDTH]) ||
                  (quot[WORD_WIDTH-1] && (|quot[WORD_WIDTH-2:0]));
   end

   // Load operands, run the digits, then round, saturate and apply sign
   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      low_in    = low_ff;
      count_in  = count_ff;
      neg_in    = neg_ff;
      busy_in   = busy_ff;
      fin_in    = 1'b0;
      done_in   = 1'b0;
      prod_in   = prod_ff;
      if (mul_req.start) begin
         mcand_in  = mul_req.op_a[WORD_WIDTH-1] ? WORD_WIDTH'(-mul_req.op_a)
                                                : WORD_WIDTH'(mul_req.op_a);
         mplier_in = mul_req.op_b[WORD_WIDTH-1] ? WORD_WIDTH'(-mul_req.op_b)
                                                : WORD_WIDTH'(mul_req.op_b);
         // rounding half of the dropped fraction rides in from the start
         acc_in    = ACC_WIDTH'(longint'(1) << (FRAC_BITS - 1));
         low_in    = '0;
         count_in  = '0;
         neg_in    = mul_req.op_a[WORD_WIDTH-1] ^ mul_req.op_b[WORD_WIDTH-1];
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         acc_in    = {{DIGIT_WIDTH{1'b0}}, digit_sum[ACC_WIDTH-1:DIGIT_WIDTH]};
         low_in    = {digit_sum[DIGIT_WIDTH-1:0], low_ff[WORD_WIDTH-1:DIGIT_WIDTH]};
         mplier_in = {{DIGIT_WIDTH{1'b0}}, mplier_ff[WORD_WIDTH-1:DIGIT_WIDTH]};
         count_in  = count_ff + 1'b1;
         if (count_ff == COUNT_WIDTH'(DIGIT_COUNT - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            prod_in = over_neg ? {1'b1, {(WORD_WIDTH - 1){1'b0}}}
                               : -signed'(quot[WORD_WIDTH-1:0]);
         end else begin
            prod_in = over_pos ? {1'b0, {(WORD_WIDTH - 1){1'b1}}}
                               : signed'(quot[WORD_WIDTH-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      low_ff    <= low_in;
      count_ff  <= count_in;
      neg_ff    <= neg_in;
      prod_ff   <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

   // A new product never starts over one still running
   assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> !busy_ff && !fin_ff)
      else $error("bsf_mul: start while a product is in flight");

   // Completion follows the rounding cycle
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(fin_ff))
      else $error("bsf_mul: done without a finishing cycle");

endmodule

### design/balance_state_feedback.sv
// balance_state_feedback: top level of the balance state-feedback controller
// with integral action. Depends on bsf_pkg and bsf_mul.
`timescale 1ns / 1ps

// One request in, one drive value out. Every product goes through a single
// radix-16 serial multiplier, which works each product in a load step, the
// digit steps, a rounding step and the step in which the sequencer takes the
// result. A request needs between 6 and 11 products (the wheel-state update
// is skipped when |wheel_speed| >= 100, the integral leak when the position is
// outside +-0.005). One request is worked at a time; the next is taken once
// the drive value sits in the output register, even while that value still
// waits to be taken. Configuration writes are always accepted and must only
// be issued while the block is idle.

module balance_state_feedback (
   input  logic                                  clock,
   input  logic                                  reset,
   // fields from bit 0 up: tilt_angle[31:0], tilt_rate[31:0], time_step[15:0],
   // wheel_speed[31:0]
   input  logic [bsf_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // fields from bit 0 up: drive[31:0]
   output logic [bsf_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [bsf_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import bsf_pkg::*;

   bsf_state_type state_ff, state_in;
   logic          run_ff, run_in;

   // Gains and wheel radius
   logic signed [WORD_WIDTH-1:0] kp_ff, kv_ff, ka_ff, kr_ff, ki_ff;
   logic [RADIUS_WIDTH-1:0]      radius_ff;

   // Captured request
   logic signed [WORD_WIDTH-1:0] angle_ff, angle_in;
   logic signed [WORD_WIDTH-1:0] rate_ff, rate_in;
   logic signed [WORD_WIDTH-1:0] speed_ff, speed_in;
   logic [STEP_WIDTH-1:0]        step_ff, step_in;

   // Controller state and working values
   logic signed [WORD_WIDTH-1:0] pos_ff, pos_in;
   logic signed [WORD_WIDTH-1:0] fv_ff, fv_in;
   logic signed [WORD_WIDTH-1:0] integ_ff, integ_in;
   logic signed [WORD_WIDTH-1:0] vel_ff, vel_in;
   logic signed [WORD_WIDTH-1:0] part_ff, part_in;
   logic signed [SUM_WIDTH-1:0]  sum_ff, sum_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]    rsp_data_ff, rsp_data_in;

   bsf_mul_req_type mul_req;
   bsf_mul_rsp_type mul_rsp;

   logic signed [SPEED_WIDTH-1:0] speed_port;
   logic                          speed_ok;
   logic                          near_origin;
   logic signed [WORD_WIDTH-1:0]  prod;
   logic signed [SUM_WIDTH-1:0]   prod_ext;
   logic signed [SUM_WIDTH:0]     neg_sum;
   logic [DRIVE_WIDTH-1:0]        drive;

   bsf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Range checks, final negate and saturate
   always_comb begin
      speed_port  = signed'(req_tdata[SPEED_LSB +: SPEED_WIDTH]);
      speed_ok    = (speed_port < SPEED_HI) && (speed_port > SPEED_LO);
      near_origin = (pos_ff < NEAR_HI) && (pos_ff > NEAR_LO);
      prod        = mul_rsp.product;
      prod_ext    = SUM_WIDTH'(prod);
      neg_sum     = -((SUM_WIDTH + 1)'(sum_ff));
      if (neg_sum > DRIVE_HI) begin
         drive = DRIVE_WIDTH'(DRIVE_HI);
      end else if (neg_sum < DRIVE_LO) begin
         drive = DRIVE_WIDTH'(DRIVE_LO);
      end else begin
         drive = DRIVE_WIDTH'(neg_sum);
      end
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_req.start = (state_ff inside {S_VEL, S_POS, S_FILT_A, S_FILT_B, S_INTEG,
                                        S_LEAK, S_GAIN_POS, S_GAIN_VEL, S_GAIN_ANGLE,
                                        S_GAIN_RATE, S_GAIN_INTEG}) && !run_ff;
      mul_req.op_a  = '0;
      mul_req.op_b  = '0;
      case (state_ff)
         S_VEL: begin
            mul_req.op_a = speed_ff;
            mul_req.op_b = WORD_WIDTH'(radius_ff);
         end
         S_POS: begin
            mul_req.op_a = vel_ff;
            mul_req.op_b = WORD_WIDTH'(step_ff);
         end
         S_FILT_A: begin
            mul_req.op_a = ALPHA_WORD;
            mul_req.op_b = vel_ff;
         end
         S_FILT_B: begin
            mul_req.op_a = ONE_LESS_ALPHA;
            mul_req.op_b = fv_ff;
         end
         S_INTEG: begin
            mul_req.op_a = pos_ff;
            mul_req.op_b = WORD_WIDTH'(step_ff);
         end
         S_LEAK: begin
            mul_req.op_a = integ_ff;
            mul_req.op_b = LEAK_WORD;
         end
         S_GAIN_POS: begin
            mul_req.op_a = kp_ff;
            mul_req.op_b = pos_ff;
         end
         S_GAIN_VEL: begin
            mul_req.op_a = kv_ff;
            mul_req.op_b = fv_ff;
         end
         S_GAIN_ANGLE: begin
            mul_req.op_a = ka_ff;
            mul_req.op_b = angle_ff;
         end
         S_GAIN_RATE: begin
            mul_req.op_a = kr_ff;
            mul_req.op_b = rate_ff;
         end
         S_GAIN_INTEG: begin
            mul_req.op_a = ki_ff;
            mul_req.op_b = integ_ff;
         end
         default: begin
            mul_req.op_a = '0;
            mul_req.op_b = '0;
         end
      endcase
   end

   // Sequencer: next state and register updates
   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      angle_in     = angle_ff;
      rate_in      = rate_ff;
      speed_in     = speed_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      fv_in        = fv_ff;
      integ_in     = integ_ff;
      vel_in       = vel_ff;
      part_in      = part_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      req_tready   = 1'b0;

      // drop the result once transferred
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_req.start) begin
         run_in = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               angle_in = WORD_WIDTH'(signed'(req_tdata[ANGLE_LSB +: ANGLE_WIDTH]));
               rate_in  = WORD_WIDTH'(signed'(req_tdata[RATE_LSB +: RATE_WIDTH]));
               speed_in = WORD_WIDTH'(speed_port);
               step_in  = req_tdata[STEP_LSB +: STEP_WIDTH];
               state_in = speed_ok ? S_VEL : S_INTEG;
            end
         end
         S_VEL: begin
            if (mul_rsp.done) begin
               vel_in   = prod;
               run_in   = 1'b0;
               state_in = S_POS;
            end
         end
         S_POS: begin
            if (mul_rsp.done) begin
               pos_in   = sat_add(pos_ff, prod);
               run_in   = 1'b0;
               state_in = S_FILT_A;
            end
         end
         S_FILT_A: begin
            if (mul_rsp.done) begin
               part_in  = prod;
               run_in   = 1'b0;
               state_in = S_FILT_B;
            end
         end
         S_FILT_B: begin
            if (mul_rsp.done) begin
               fv_in    = sat_add(part_ff, prod);
               run_in   = 1'b0;
               state_in = S_INTEG;
            end
         end
         S_INTEG: begin
            if (mul_rsp.done) begin
               integ_in = sat_add(integ_ff, prod);
               run_in   = 1'b0;
               state_in = near_origin ? S_LEAK : S_CLAMP;
            end
         end
         S_LEAK: begin
            if (mul_rsp.done) begin
               integ_in = prod;
               run_in   = 1'b0;
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            if (integ_ff > INTEG_HI) begin
               integ_in = INTEG_HI;
            end else if (integ_ff < INTEG_LO) begin
               integ_in = INTEG_LO;
            end
            state_in = S_GAIN_POS;
         end
         S_GAIN_POS: begin
            if (mul_rsp.done) begin
               sum_in   = prod_ext;
               run_in   = 1'b0;
               state_in = S_GAIN_VEL;
            end
         end
         S_GAIN_VEL: begin
            if (mul_rsp.done) begin
               sum_in   = sum_ff + prod_ext;
               run_in   = 1'b0;
               state_in = S_GAIN_ANGLE;
            end
         end
         S_GAIN_ANGLE: begin
            if (mul_rsp.done) begin
               sum_in   = sum_ff + prod_ext;
               run_in   = 1'b0;
               state_in = S_GAIN_RATE;
            end
         end
         S_GAIN_RATE: begin
            if (mul_rsp.done) begin
               sum_in   = sum_ff + prod_ext;
               run_in   = 1'b0;
               state_in = S_GAIN_INTEG;
            end
         end
         S_GAIN_INTEG: begin
            if (mul_rsp.done) begin
               sum_in   = sum_ff + prod_ext;
               run_in   = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = drive;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
            run_in   = 1'b0;
         end
      endcase
   end

   // Sequencer, controller state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         fv_ff        <= '0;
         integ_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         fv_ff        <= fv_in;
         integ_ff     <= integ_in;
      end
      angle_ff    <= angle_in;
      rate_ff     <= rate_in;
      speed_ff    <= speed_in;
      step_ff     <= step_in;
      vel_ff      <= vel_in;
      part_ff     <= part_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff     <= '0;
         kv_ff     <= '0;
         ka_ff     <= '0;
         kr_ff     <= '0;
         ki_ff     <= '0;
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_POSITION:   kp_ff     <= WORD_WIDTH'(signed'(csr_data[GAIN_WIDTH-1:0]));
            CSR_GAIN_VELOCITY:   kv_ff     <= WORD_WIDTH'(signed'(csr_data[GAIN_WIDTH-1:0]));
            CSR_GAIN_ANGLE:      ka_ff     <= WORD_WIDTH'(signed'(csr_data[GAIN_WIDTH-1:0]));
            CSR_GAIN_ANGLE_RATE: kr_ff     <= WORD_WIDTH'(signed'(csr_data[GAIN_WIDTH-1:0]));
            CSR_GAIN_INTEGRAL:   ki_ff     <= WORD_WIDTH'(signed'(csr_data[GAIN_WIDTH-1:0]));
            CSR_WHEEL_RADIUS:    radius_ff <= csr_data[RADIUS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // The integral is inside its clamp whenever the gain products start
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_GAIN_POS |-> (integ_ff <= INTEG_HI) && (integ_ff >= INTEG_LO))
      else $error("balance_state_feedback: integral outside clamp");

   // Multiplier results only arrive for a product that was issued
   assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> run_ff)
      else $error("balance_state_feedback: unexpected multiplier result");

   // A new result appears only out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("balance_state_feedback: result raised outside output step");

endmodule
